// ===== src/pspc_pkg.sv =====
// pspc_pkg: shared types, widths and register codes of the precharge slope pwm control
// used by the channel interfaces and the top level; depends on nothing

package pspc_pkg;

    // history ring and filter shape
    localparam int HISTORY_DEPTH     = 16;
    localparam int HIST_AW           = $clog2(HISTORY_DEPTH);
    localparam int HISTORY_AVG_COUNT = 4;
    localparam int AVG_SHIFT         = $clog2(HISTORY_AVG_COUNT);
    localparam int UPDATE_INTERVAL   = 8;
    localparam int FILTER_DIVISOR    = 8;
    localparam int FILTER_SHIFT      = $clog2(FILTER_DIVISOR);
    localparam int PWM_FULL          = 4095;

    // field and datapath widths
    localparam int SAMPLE_W = 10;
    localparam int FRAC_W   = 16;
    localparam int AVG_W    = SAMPLE_W + FRAC_W;
    localparam int SUM_W    = AVG_W + AVG_SHIFT;
    localparam int TICK_W   = 4;
    localparam int TICK_IW  = $clog2(TICK_W);
    localparam int LIMIT_W  = 15;
    localparam int TICKUS_W = 14;
    localparam int BASE_W   = 20;
    localparam int ELAP_W   = 21;
    localparam int DUTY_W   = 12;
    localparam int SLOPE_W  = 18;
    localparam int SCALE_W  = 20;
    localparam int PROD_W   = SAMPLE_W + SCALE_W;
    localparam int QUO2_W   = FRAC_W + 1;
    localparam int CNT_MAX  = (PROD_W > HISTORY_DEPTH) ? PROD_W : HISTORY_DEPTH;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);

    // arithmetic constants
    localparam int SLOPE_SCALE = 1000000;
    localparam int SLOPE_CLAMP = 32767;

    // register reset values
    localparam int SLOPE_LIMIT_RST = 1165;
    localparam int TICK_US_RST     = 100;
    localparam int HIST_BASE_RST   = 11200;

    // apb port
    localparam int APB_DW = 32;
    localparam int APB_AW = 4;

    typedef logic [SAMPLE_W-1:0]       t_sample;
    typedef logic [DUTY_W-1:0]         t_duty;
    typedef logic signed [SLOPE_W-1:0] t_slope;
    typedef logic [AVG_W-1:0]          t_avg;

    localparam t_slope SLOPE_FLOOR = {1'b1, {(SLOPE_W-1){1'b0}}};

    // register indexes (word address)
    typedef enum logic [APB_AW-3:0] {
        REG_SLOPE_LIMIT = 2'd0,
        REG_TICK_US     = 2'd1,
        REG_HIST_BASE   = 2'd2
    } t_reg_idx;

endpackage

// ===== src/pspc_if.sv =====
// pspc_in_if / pspc_out_if: valid-ready channels for sample beats and result beats
// depends on pspc_pkg for the payload types

interface pspc_in_if;
    import pspc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample vout_sample;
    logic    enable;

    modport source (output valid, output vout_sample, output enable, input ready);
    modport sink   (input valid, input vout_sample, input enable, output ready);
endinterface

interface pspc_out_if;
    import pspc_pkg::*;

    logic    valid;
    logic    ready;
    t_duty   pwm_duty;
    t_slope  slope;
    t_sample vout_filtered;

    modport source (output valid, output pwm_duty, output slope, output vout_filtered,
                    input ready);
    modport sink   (input valid, input pwm_duty, input slope, input vout_filtered,
                    output ready);
endinterface

// ===== src/pspc_ram.sv =====
// pspc_ram: generic single-write, single-read ram with registered read data
// standalone, no package dependency

module pspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/precharge_slope_pwm_control.sv =====
// precharge_slope_pwm_control: per-tick precharge duty from the output voltage slope
// depends on pspc_pkg, pspc_in_if / pspc_out_if and pspc_ram
//
//  channel   dir  handshake         payload
//  i_in      in   valid/ready       vout_sample[9:0], enable
//  o_out     out  valid/ready       pwm_duty[11:0], slope[17:0] signed, vout_filtered[9:0]
//  apb       in   psel/penable      paddr[3:0], pwdata[31:0], prdata[31:0], pready=1
//
//  one tick at a time: a taken sample beat runs history read, elapsed time, bit-serial
//  multiply, 30-step restoring divide, evaluate and finish; a second division and a duty
//  step come before finish for a non-negative slope within limit, enable high; the first
//  tick after reset first seeds all 16 history ram entries, one entry a cycle; a finished
//  result waits in the output register while the next sample beat is taken
//  reset is synchronous, active low; config registers return to their reset values

module precharge_slope_pwm_control (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    pspc_in_if.sink                       i_in,
    pspc_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pspc_pkg::APB_AW-1:0]   paddr,
    input  logic [pspc_pkg::APB_DW-1:0]   pwdata,
    output logic [pspc_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import pspc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_SEED = 10'b00_0000_0010,
        S_READ = 10'b00_0000_0100,
        S_ELAP = 10'b00_0000_1000,
        S_MUL  = 10'b00_0001_0000,
        S_DIV1 = 10'b00_0010_0000,
        S_EVAL = 10'b00_0100_0000,
        S_DIV2 = 10'b00_1000_0000,
        S_DUTY = 10'b01_0000_0000,
        S_FIN  = 10'b10_0000_0000
    } t_state;

    // control state
    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_first, n_first;
    t_avg                r_avg, n_avg;
    logic [HIST_AW-1:0]  r_wr_idx, n_wr_idx;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic                r_ovld, n_ovld;

    // config registers
    logic [LIMIT_W-1:0]  r_slope_limit;
    logic [TICKUS_W-1:0] r_tick_us;
    logic [BASE_W-1:0]   r_hist_base;

    // datapath
    t_sample             r_sample, n_sample;
    logic                r_enable, n_enable;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic                r_neg, n_neg;
    logic [SAMPLE_W-1:0] r_mag, n_mag;
    logic [ELAP_W-1:0]   r_div, n_div;
    logic [ELAP_W-1:0]   r_rem, n_rem;
    logic [PROD_W-1:0]   r_dvd, n_dvd;
    t_slope              r_slope, n_slope;
    t_duty               r_duty, n_duty;
    t_duty               r_o_duty, n_o_duty;
    t_slope              r_o_slope, n_o_slope;
    t_sample             r_o_filt, n_o_filt;

    // ram port
    logic                ram_we;
    logic [HIST_AW-1:0]  ram_waddr;
    t_avg                ram_wdata;
    logic [HIST_AW-1:0]  ram_raddr;
    t_avg                ram_rdata;

    // helpers
    logic                in_fire;
    logic                cfg_wr;
    logic [LIMIT_W-1:0]  limit_eff;
    t_avg                seeded;
    t_avg                avg_base;
    logic [SAMPLE_W:0]   delta;
    logic                tick_bit;
    logic [ELAP_W-1:0]   elap_step;
    logic [ELAP_W-1:0]   elap_sum;
    logic [ELAP_W:0]     rem_sh;
    logic                div_ge;
    logic                floor_hit;
    logic [LIMIT_W-1:0]  pos;
    logic [QUO2_W-1:0]   frac;
    logic [QUO2_W+DUTY_W-1:0] duty_prod;

    pspc_ram #(
        .WIDTH (AVG_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && (r_state == S_IDLE);
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    assign o_out.valid         = r_ovld;
    assign o_out.pwm_duty      = r_o_duty;
    assign o_out.slope         = r_o_slope;
    assign o_out.vout_filtered = r_o_filt;

    // apb read mux
    always_comb begin
        case (t_reg_idx'(paddr[APB_AW-1:2]))
            REG_SLOPE_LIMIT: prdata = APB_DW'(r_slope_limit);
            REG_TICK_US:     prdata = APB_DW'(r_tick_us);
            REG_HIST_BASE:   prdata = APB_DW'(r_hist_base);
            default:         prdata = '0;
        endcase
    end

    // shared arithmetic
    assign limit_eff = (r_slope_limit == '0) ? LIMIT_W'(1) : r_slope_limit;
    assign seeded    = t_avg'(i_in.vout_sample) << FRAC_W;
    assign avg_base  = r_first ? seeded : r_avg;
    assign delta     = {1'b0, r_sample} - {1'b0, r_sum[SUM_W-1 -: SAMPLE_W]};
    assign tick_bit  = r_tick[TICK_IW'(TICK_W-1) - r_cnt[TICK_IW-1:0]];
    assign elap_step = {r_div[ELAP_W-2:0], 1'b0} + (tick_bit ? ELAP_W'(r_tick_us) : '0);
    assign elap_sum  = elap_step + ELAP_W'(r_hist_base);
    assign rem_sh    = {r_rem, r_dvd[PROD_W-1]};
    assign div_ge    = rem_sh >= {1'b0, r_div};
    assign floor_hit = |r_dvd[PROD_W-1:SLOPE_W-1];
    assign pos       = (|r_dvd[PROD_W-1:LIMIT_W]) ? LIMIT_W'(SLOPE_CLAMP)
                                                   : r_dvd[LIMIT_W-1:0];
    assign frac      = QUO2_W'(1 << FRAC_W) - r_dvd[QUO2_W-1:0];
    assign duty_prod = (QUO2_W+DUTY_W)'(frac) * (QUO2_W+DUTY_W)'(PWM_FULL);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_avg     = r_avg;
        n_wr_idx  = r_wr_idx;
        n_tick    = r_tick;
        n_ovld    = r_ovld;
        n_sample  = r_sample;
        n_enable  = r_enable;
        n_sum     = r_sum;
        n_neg     = r_neg;
        n_mag     = r_mag;
        n_div     = r_div;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_slope   = r_slope;
        n_duty    = r_duty;
        n_o_duty  = r_o_duty;
        n_o_slope = r_o_slope;
        n_o_filt  = r_o_filt;
        ram_we    = 1'b0;
        ram_waddr = r_wr_idx;
        ram_wdata = r_avg;
        ram_raddr = r_wr_idx + r_cnt[HIST_AW-1:0];

        if (r_ovld && o_out.ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            // take a sample beat and update the average
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sample = i_in.vout_sample;
                    n_enable = i_in.enable;
                    n_tick   = r_tick + TICK_W'(1);
                    n_avg    = avg_base - (avg_base >> FILTER_SHIFT)
                             + (seeded >> FILTER_SHIFT);
                    n_first  = 1'b0;
                    n_cnt    = '0;
                    n_sum    = '0;
                    n_state  = r_first ? S_SEED : S_READ;
                end
            end
            // first tick: fill every ring entry with the sample
            S_SEED: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[HIST_AW-1:0];
                ram_wdata = t_avg'(r_sample) << FRAC_W;
                n_cnt     = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HISTORY_DEPTH - 1)) begin
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            // sum the oldest entries, read data is registered so it arrives in the cycle after its address
            S_READ: begin
                if (r_cnt != '0) begin
                    n_sum = r_sum + SUM_W'(ram_rdata);
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HISTORY_AVG_COUNT)) begin
                    n_cnt   = '0;
                    n_div   = '0;
                    n_state = S_ELAP;
                end
            end
            // elapsed time, tick count taken msb first
            S_ELAP: begin
                n_neg = delta[SAMPLE_W];
                n_mag = delta[SAMPLE_W] ? SAMPLE_W'(-delta) : delta[SAMPLE_W-1:0];
                n_div = elap_step;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TICK_W - 1)) begin
                    n_div   = (elap_sum == '0) ? ELAP_W'(1) : elap_sum;
                    n_cnt   = '0;
                    n_dvd   = '0;
                    n_state = S_MUL;
                end
            end
            // magnitude times the scale, one bit a cycle
            S_MUL: begin
                n_mag = {r_mag[SAMPLE_W-2:0], 1'b0};
                n_dvd = {r_dvd[PROD_W-2:0], 1'b0}
                      + (r_mag[SAMPLE_W-1] ? PROD_W'(SLOPE_SCALE) : '0);
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(SAMPLE_W - 1)) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_DIV1;
                end
            end
            // restoring division steps, shared by both divides
            S_DIV1, S_DIV2: begin
                n_rem = div_ge ? ELAP_W'(rem_sh - {1'b0, r_div}) : rem_sh[ELAP_W-1:0];
                n_dvd = {r_dvd[PROD_W-2:0], div_ge};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_state == S_DIV1 && r_cnt == CNT_W'(PROD_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_EVAL;
                end
                if (r_state == S_DIV2 && r_cnt == CNT_W'(QUO2_W - 1)) begin
                    n_cnt   = '0;
                    n_state = S_DUTY;
                end
            end
            // sign, clamps and the duty shortcuts
            S_EVAL: begin
                if (r_neg) begin
                    n_slope = floor_hit ? SLOPE_FLOOR : (SLOPE_W'(0) - r_dvd[SLOPE_W-1:0]);
                    n_duty  = r_enable ? DUTY_W'(PWM_FULL) : '0;
                    n_state = S_FIN;
                end else begin
                    n_slope = SLOPE_W'(pos);
                    if (!r_enable || pos > limit_eff) begin
                        n_duty  = '0;
                        n_state = S_FIN;
                    end else begin
                        n_rem   = ELAP_W'(pos >> 1);
                        n_dvd   = {pos[0], {(PROD_W-1){1'b0}}};
                        n_div   = ELAP_W'(limit_eff);
                        n_state = S_DIV2;
                    end
                end
            end
            // duty from the remaining fraction
            S_DUTY: begin
                n_duty  = duty_prod[FRAC_W +: DUTY_W];
                n_state = S_FIN;
            end
            // result beat, and the history write once the update interval is reached
            S_FIN: begin
                if (!r_ovld || o_out.ready) begin
                    n_ovld    = 1'b1;
                    n_o_duty  = r_duty;
                    n_o_slope = r_slope;
                    n_o_filt  = r_avg[AVG_W-1 -: SAMPLE_W];
                    if (r_tick >= TICK_W'(UPDATE_INTERVAL)) begin
                        ram_we   = 1'b1;
                        n_tick   = '0;
                        n_wr_idx = r_wr_idx + HIST_AW'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_first       <= 1'b1;
            r_avg         <= '0;
            r_wr_idx      <= '0;
            r_tick        <= '0;
            r_ovld        <= 1'b0;
            r_slope_limit <= LIMIT_W'(SLOPE_LIMIT_RST);
            r_tick_us     <= TICKUS_W'(TICK_US_RST);
            r_hist_base   <= BASE_W'(HIST_BASE_RST);
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_first  <= n_first;
            r_avg    <= n_avg;
            r_wr_idx <= n_wr_idx;
            r_tick   <= n_tick;
            r_ovld   <= n_ovld;
            if (cfg_wr) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_SLOPE_LIMIT: r_slope_limit <= pwdata[LIMIT_W-1:0];
                    REG_TICK_US:     r_tick_us     <= pwdata[TICKUS_W-1:0];
                    REG_HIST_BASE:   r_hist_base   <= pwdata[BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_sample  <= n_sample;
        r_enable  <= n_enable;
        r_sum     <= n_sum;
        r_neg     <= n_neg;
        r_mag     <= n_mag;
        r_div     <= n_div;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_slope   <= n_slope;
        r_duty    <= n_duty;
        r_o_duty  <= n_o_duty;
        r_o_slope <= n_o_slope;
        r_o_filt  <= n_o_filt;
    end

    // a taken sample beat always starts work and clears the first-tick flag
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE) && !r_first)
        else $error("sample beat did not start a tick");

    // tick counter never runs past the update interval
    a_tick_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tick <= TICK_W'(UPDATE_INTERVAL))
        else $error("tick counter out of range");

    // nonzero duty with a positive slope needs the slope within the limit
    a_duty_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_o_duty != '0 && !r_o_slope[SLOPE_W-1])
            |-> (r_o_slope[LIMIT_W-1:0] <= limit_eff))
        else $error("duty driven above slope limit");

endmodule
